>>> hw/rtl/svpwm_pkg.sv
// svpwm_pkg: field widths, fixed-point constants and payload/pipeline types
// for the min-max injection SVPWM duty generator. No dependencies.
`default_nettype none

package svpwm_pkg;

    localparam int VOLT_BITS = 16;
    localparam int DUTY_BITS = 16;
    localparam int VOLT_FRAC = 8;
    localparam int BUS_BITS  = VOLT_BITS - 1;
    localparam int PH_BITS   = VOLT_BITS + 16;
    localparam int DIFF_BITS = PH_BITS + 2;
    localparam int DEN_BITS  = BUS_BITS + 16;
    localparam int COEF_BITS = 16;

    // sqrt(3)/2 in Q1.15
    localparam logic signed [COEF_BITS-1:0] SQ3H_Q15 = 16'sd28378;

    localparam logic [BUS_BITS-1:0]  BUS_MIN   = BUS_BITS'(1) << VOLT_FRAC;
    localparam logic [DUTY_BITS:0]   DUTY_FULL = (DUTY_BITS+1)'(1) << DUTY_BITS;
    localparam logic [DUTY_BITS:0]   DUTY_HALF = (DUTY_BITS+1)'(1) << (DUTY_BITS - 1);

    typedef struct packed {
        logic signed [VOLT_BITS-1:0] alpha_volts;
        logic signed [VOLT_BITS-1:0] beta_volts;
        logic        [BUS_BITS-1:0]  bus_volts;
    } t_svpwm_in;

    typedef struct packed {
        logic [DUTY_BITS:0] phase_a_duty;
        logic [DUTY_BITS:0] phase_b_duty;
        logic [DUTY_BITS:0] phase_c_duty;
    } t_svpwm_out;

    typedef struct packed {
        logic                 neg;
        logic                 sat;
        logic [DEN_BITS-1:0]  rem;
        logic [DUTY_BITS-1:0] q;
    } t_div_lane;

    typedef struct packed {
        logic                valid;
        logic [DEN_BITS-1:0] den;
        t_div_lane [2:0]     lane;
    } t_div_stage;

endpackage

`default_nettype wire

>>> hw/rtl/svpwm_minmax_duty.sv
// svpwm_minmax_duty: inverse Clarke, min-max zero-sequence injection and
// per-phase pipelined restoring division to Q1.16 duty. Uses svpwm_pkg.
//
//  channel   dir  handshake              payload
//  request   in   start / busy           i_req  (t_svpwm_in)
//  result    out  o_strobe (one cycle)   o_res  (t_svpwm_out)
//
// One request per cycle; busy stays low. The pipeline registers are: multiply,
// Clarke sum, min/max, shift and magnitude, then one quotient bit per stage in
// three parallel divider lanes, then the output register. Synchronous reset
// clears the valid bits only.
`default_nettype none

module svpwm_minmax_duty
    import svpwm_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire t_svpwm_in  i_req,
    output logic            o_strobe,
    output t_svpwm_out      o_res
);

    localparam int LATENCY = 5 + DUTY_BITS;

    // stage 1: beta product, bus clamp
    logic                        r_s1_valid;
    logic signed [VOLT_BITS-1:0] r_s1_al;
    logic signed [PH_BITS-1:0]   r_s1_bk;
    logic        [BUS_BITS-1:0]  r_s1_bus;
    logic signed [PH_BITS-1:0]   n_s1_bk;
    logic        [BUS_BITS-1:0]  n_s1_bus;

    // stage 2: phase voltages
    logic                        r_s2_valid;
    logic signed [PH_BITS-1:0]   r_s2_ph [3];
    logic        [BUS_BITS-1:0]  r_s2_bus;
    logic signed [PH_BITS-1:0]   n_s2_ph [3];

    // stage 3: max + min
    logic                        r_s3_valid;
    logic signed [PH_BITS-1:0]   r_s3_ph [3];
    logic signed [PH_BITS:0]     r_s3_sum;
    logic        [BUS_BITS-1:0]  r_s3_bus;
    logic signed [PH_BITS:0]     n_s3_sum;

    // divider pipeline
    t_div_stage r_div [0:DUTY_BITS];
    t_div_stage n_div [0:DUTY_BITS];

    logic       r_out_valid;
    t_svpwm_out r_out;
    t_svpwm_out n_out;

    assign busy = 1'b0;

    always_comb begin
        n_s1_bk  = PH_BITS'(i_req.beta_volts) * PH_BITS'(SQ3H_Q15);
        n_s1_bus = (i_req.bus_volts < BUS_MIN) ? BUS_MIN : i_req.bus_volts;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= start && !busy;
        end
        r_s1_al  <= i_req.alpha_volts;
        r_s1_bk  <= n_s1_bk;
        r_s1_bus <= n_s1_bus;
    end

    logic signed [PH_BITS-1:0] w_al_ext;
    logic signed [PH_BITS-1:0] w_al_half;

    always_comb begin
        w_al_ext   = PH_BITS'(r_s1_al);
        w_al_half  = w_al_ext <<< 14;
        n_s2_ph[0] = w_al_ext <<< 15;
        n_s2_ph[1] = r_s1_bk - w_al_half;
        n_s2_ph[2] = -w_al_half - r_s1_bk;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
        r_s2_ph  <= n_s2_ph;
        r_s2_bus <= r_s1_bus;
    end

    logic signed [PH_BITS-1:0] w_mx;
    logic signed [PH_BITS-1:0] w_mn;

    always_comb begin
        w_mx = r_s2_ph[0];
        w_mn = r_s2_ph[0];
        if (r_s2_ph[1] > w_mx) w_mx = r_s2_ph[1];
        if (r_s2_ph[2] > w_mx) w_mx = r_s2_ph[2];
        if (r_s2_ph[1] < w_mn) w_mn = r_s2_ph[1];
        if (r_s2_ph[2] < w_mn) w_mn = r_s2_ph[2];
        n_s3_sum = (PH_BITS+1)'(w_mx) + (PH_BITS+1)'(w_mn);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid;
        end
        r_s3_ph  <= r_s2_ph;
        r_s3_sum <= n_s3_sum;
        r_s3_bus <= r_s2_bus;
    end

    // shifted phase D = 2*v - (max + min), sign/magnitude, saturation
    logic signed [DIFF_BITS-1:0] w_d   [3];
    logic        [DIFF_BITS-1:0] w_mag [3];
    logic        [DEN_BITS-1:0]  w_den;

    always_comb begin
        w_den           = {r_s3_bus, 16'b0};
        n_div[0].valid  = r_s3_valid;
        n_div[0].den    = w_den;
        for (int k = 0; k < 3; k++) begin
            w_d[k]   = (DIFF_BITS'(r_s3_ph[k]) <<< 1) - DIFF_BITS'(r_s3_sum);
            w_mag[k] = w_d[k][DIFF_BITS-1] ? DIFF_BITS'(-w_d[k]) : DIFF_BITS'(w_d[k]);
            n_div[0].lane[k].neg = w_d[k][DIFF_BITS-1];
            n_div[0].lane[k].sat = {w_mag[k], 1'b0} >= (DIFF_BITS+1)'(w_den);
            n_div[0].lane[k].rem = DEN_BITS'(w_mag[k]);
            n_div[0].lane[k].q   = '0;
        end
    end

    for (genvar s = 0; s < DUTY_BITS; s++) begin : g_div
        logic [DEN_BITS:0] w_t [3];
        logic              w_ge [3];

        always_comb begin
            n_div[s+1].valid = r_div[s].valid;
            n_div[s+1].den   = r_div[s].den;
            for (int k = 0; k < 3; k++) begin
                w_t[k]  = {r_div[s].lane[k].rem, 1'b0};
                w_ge[k] = w_t[k] >= {1'b0, r_div[s].den};
                n_div[s+1].lane[k].neg = r_div[s].lane[k].neg;
                n_div[s+1].lane[k].sat = r_div[s].lane[k].sat;
                n_div[s+1].lane[k].rem = w_ge[k]
                    ? DEN_BITS'(w_t[k] - {1'b0, r_div[s].den})
                    : DEN_BITS'(w_t[k]);
                n_div[s+1].lane[k].q = {r_div[s].lane[k].q[DUTY_BITS-2:0], w_ge[k]};
            end
        end
    end

    for (genvar s = 0; s <= DUTY_BITS; s++) begin : g_div_reg
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_div[s].valid <= 1'b0;
            end else begin
                r_div[s].valid <= n_div[s].valid;
            end
            r_div[s].den  <= n_div[s].den;
            r_div[s].lane <= n_div[s].lane;
        end
    end

    logic [DUTY_BITS:0] w_duty [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_div[DUTY_BITS].lane[k].sat) begin
                w_duty[k] = r_div[DUTY_BITS].lane[k].neg ? '0 : DUTY_FULL;
            end else if (r_div[DUTY_BITS].lane[k].neg) begin
                w_duty[k] = DUTY_HALF - (DUTY_BITS+1)'(r_div[DUTY_BITS].lane[k].q);
            end else begin
                w_duty[k] = DUTY_HALF + (DUTY_BITS+1)'(r_div[DUTY_BITS].lane[k].q);
            end
        end
        n_out.phase_a_duty = w_duty[0];
        n_out.phase_b_duty = w_duty[1];
        n_out.phase_c_duty = w_duty[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_div[DUTY_BITS].valid;
        end
        r_out <= n_out;
    end

    assign o_strobe = r_out_valid;
    assign o_res    = r_out;

`ifndef ASSERT_OFF
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, LATENCY))
        else $error("result strobe without matching request");

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_res.phase_a_duty <= DUTY_FULL) && (o_res.phase_b_duty <= DUTY_FULL)
                     && (o_res.phase_c_duty <= DUTY_FULL))
        else $error("duty above full scale");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div[DUTY_BITS].valid |->
            (r_div[DUTY_BITS].lane[0].sat || r_div[DUTY_BITS].lane[0].rem < r_div[DUTY_BITS].den)
         && (r_div[DUTY_BITS].lane[1].sat || r_div[DUTY_BITS].lane[1].rem < r_div[DUTY_BITS].den)
         && (r_div[DUTY_BITS].lane[2].sat || r_div[DUTY_BITS].lane[2].rem < r_div[DUTY_BITS].den))
        else $error("divider remainder out of range");
`endif

endmodule

`default_nettype wire

>>> verif/svpwm_checker.sv
// svpwm_checker: watches the request and result channels of svpwm_minmax_duty,
// predicts the three phase duties of every accepted request and compares them.
// Depends on svpwm_pkg for the payload types and field widths.
`timescale 1ns / 1ps

module svpwm_checker
    import svpwm_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire logic       i_busy,
    input  wire t_svpwm_in  i_req,
    input  wire logic       i_strobe,
    input  wire t_svpwm_out i_res,
    output int              o_fail_count,
    output int              o_pending,
    output int              o_checked
);

    localparam longint SQRT3_HALF_Q15 = 28378;
    localparam longint LOW_BUS        = 256;

    t_svpwm_out duty_queue[$];
    int         fails   = 0;
    int         checked = 0;

    assign o_fail_count = fails;
    assign o_pending    = duty_queue.size();
    assign o_checked    = checked;

    task automatic report(string what, longint want, longint got);
        $display("[%0t] MISMATCH %s: expected %0d, got %0d", $realtime, what, want, got);
        fails++;
    endtask

    // offset = 2*v - (max + min), scaled by 2^23; divided by 2^16 * bus
    function automatic logic [DUTY_BITS:0] phase_duty(longint offset, longint bus);
        longint den;
        longint mag;
        longint rem;
        longint quo;
        bit     neg;
        den = bus << 16;
        neg = offset < 0;
        mag = neg ? -offset : offset;
        if (mag * 2 >= den) begin
            return neg ? '0 : (DUTY_BITS+1)'(longint'(1) << DUTY_BITS);
        end
        rem = mag;
        quo = 0;
        for (int i = 0; i < DUTY_BITS; i++) begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | 1;
            end
        end
        if (neg) begin
            return (DUTY_BITS+1)'((longint'(1) << (DUTY_BITS - 1)) - quo);
        end
        return (DUTY_BITS+1)'((longint'(1) << (DUTY_BITS - 1)) + quo);
    endfunction

    function automatic t_svpwm_out predict_duties(t_svpwm_in req);
        longint     alpha;
        longint     beta;
        longint     bus;
        longint     ph[3];
        longint     hi;
        longint     lo;
        t_svpwm_out res;
        alpha = longint'(signed'(req.alpha_volts));
        beta  = longint'(signed'(req.beta_volts));
        bus   = longint'(req.bus_volts);
        if (bus < LOW_BUS) begin
            bus = LOW_BUS;
        end
        ph[0] = alpha * 32768;
        ph[1] = -alpha * 16384 + beta * SQRT3_HALF_Q15;
        ph[2] = -alpha * 16384 - beta * SQRT3_HALF_Q15;
        hi = ph[0];
        lo = ph[0];
        for (int k = 1; k < 3; k++) begin
            if (ph[k] > hi) hi = ph[k];
            if (ph[k] < lo) lo = ph[k];
        end
        res.phase_a_duty = phase_duty(2 * ph[0] - (hi + lo), bus);
        res.phase_b_duty = phase_duty(2 * ph[1] - (hi + lo), bus);
        res.phase_c_duty = phase_duty(2 * ph[2] - (hi + lo), bus);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_svpwm_out want;
        if (i_rst_n) begin
            if (i_start && !i_busy) begin
                duty_queue.push_back(predict_duties(i_req));
            end
            if (i_strobe) begin
                if (duty_queue.size() == 0) begin
                    report("unexpected result, phase A duty", -1, i_res.phase_a_duty);
                end else begin
                    want = duty_queue.pop_front();
                    checked++;
                    if (i_res.phase_a_duty !== want.phase_a_duty)
                        report("phase A duty", want.phase_a_duty, i_res.phase_a_duty);
                    if (i_res.phase_b_duty !== want.phase_b_duty)
                        report("phase B duty", want.phase_b_duty, i_res.phase_b_duty);
                    if (i_res.phase_c_duty !== want.phase_c_duty)
                        report("phase C duty", want.phase_c_duty, i_res.phase_c_duty);
                end
            end
        end
    end

endmodule

>>> verif/tb_top.sv
// tb_top: stimulus and verdict for svpwm_minmax_duty; directed corner requests,
// then random reference vectors with random gaps. Uses svpwm_pkg and svpwm_checker.
`timescale 1ns / 1ps

module tb_top;
    import svpwm_pkg::*;

    localparam int RANDOM_REQUESTS = 1900;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 40;

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start   = 1'b0;
    t_svpwm_in  i_req   = '0;
    logic       busy;
    logic       o_strobe;
    t_svpwm_out o_res;

    int fail_count;
    int pending;
    int checked;
    int cycles    = 0;
    int sent      = 0;
    bit no_gaps   = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    svpwm_minmax_duty DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    svpwm_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (i_req),
        .i_strobe     (o_strobe),
        .i_res        (o_res),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_request(logic signed [VOLT_BITS-1:0] alpha,
                                logic signed [VOLT_BITS-1:0] beta,
                                logic [BUS_BITS-1:0] bus);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start             <= 1'b1;
        i_req.alpha_volts <= alpha;
        i_req.beta_volts  <= beta;
        i_req.bus_volts   <= bus;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sent++;
    endtask

    function automatic logic signed [VOLT_BITS-1:0] signed_within(int lim);
        return VOLT_BITS'($urandom_range(0, 2 * lim) - lim);
    endfunction

    initial begin
        int bus;
        int lim;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero vector, axis extremes, low bus, saturation edge, bit patterns
        send_request(16'sd0, 16'sd0, 15'd3072);
        send_request(16'sh7FFF, 16'sd0, 15'h7FFF);
        send_request(-16'sh8000, 16'sd0, 15'h7FFF);
        send_request(16'sd0, 16'sh7FFF, 15'h7FFF);
        send_request(16'sd0, -16'sh8000, 15'h7FFF);
        send_request(16'sh7FFF, 16'sh7FFF, 15'd0);
        send_request(-16'sh8000, -16'sh8000, 15'd0);
        send_request(16'sd10, 16'sd0, 15'd0);
        send_request(16'sd64, -16'sd64, 15'd255);
        send_request(16'sd100, 16'sd50, 15'd256);
        send_request(16'sd100, 16'sd50, 15'd257);
        send_request(-16'sd200, 16'sd300, 15'd4096);
        send_request(16'sd200, 16'sd0, 15'd300);
        send_request(16'sd199, 16'sd0, 15'd300);
        send_request(-16'sd200, 16'sd0, 15'd300);
        send_request(-16'sd199, 16'sd0, 15'd300);
        send_request(16'sd1, 16'sd0, 15'h7FFF);
        send_request(-16'sd1, -16'sd1, 15'd1);
        send_request(16'sh5555, -16'sh5556, 15'h2AAA);
        send_request(-16'sh5556, 16'sh5555, 15'h5555);
        send_request(16'sd1000, 16'sd577, 15'd2000);

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 64 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0) begin
                send_request(VOLT_BITS'($urandom), VOLT_BITS'($urandom), BUS_BITS'($urandom));
            end else begin
                bus = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 300)
                                                  : $urandom_range(0, 32767);
                lim = (bus < 256) ? 256 : bus;
                lim = lim * $urandom_range(1, 12) / 16;
                if (lim > 32767) lim = 32767;
                send_request(signed_within(lim), signed_within(lim), BUS_BITS'(bus));
            end
        end
        start <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d duty requests (21 directed corners, rest random with gaps)", sent);
        $display("Compared %0d three-phase duty results across low, mid and full bus", checked);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
